@@ sv/g3ne_pkg.sv @@
// ----------------------------------------------------------------------------
// g3ne_pkg
// shared widths, types and helpers of the 3d grid neighbor edge generator
// ----------------------------------------------------------------------------
package g3ne_pkg;

    localparam int MAX_DIM       = 1024;
    localparam int MAX_NEIGHBORS = 6;
    localparam int WEIGHT_MOD    = 16;
    localparam int WGT_BITS      = $clog2(WEIGHT_MOD);

    localparam int DIM_W  = 11;   // grid dimension register
    localparam int HW_W   = 21;   // first_dim * second_dim
    localparam int TOT_W  = 31;   // vertex total, also divisor width
    localparam int LAB_W  = 30;   // label without base, also dividend width
    localparam int OUT_W  = 31;   // labels including base
    localparam int MULT_W = 31;   // hash multiplier
    localparam int EDGE_W = 33;   // running edge count
    localparam int WGT_W  = 5;    // edge weight
    localparam int CNT_W  = 5;    // serial step counter
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // neighbor direction bit positions, in emission order
    localparam int DIR_ZP = 0;
    localparam int DIR_ZM = 1;
    localparam int DIR_YP = 2;
    localparam int DIR_YM = 3;
    localparam int DIR_XP = 4;
    localparam int DIR_XM = 5;

    typedef enum logic [2:0] {
        REG_FIRST_DIM  = 3'd0,
        REG_SECOND_DIM = 3'd1,
        REG_THIRD_DIM  = 3'd2,
        REG_BASE_VALUE = 3'd3,
        REG_LABEL_MODE = 3'd4,
        REG_HASH_MULT  = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_HASH_GO,
        ST_HASH_WAIT,
        ST_Z_GO,
        ST_Z_WAIT,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [LAB_W-1:0] quot;
        logic [TOT_W-1:0] rem;
    } t_div_res;

    typedef struct packed {
        logic             done;
        logic [LAB_W-1:0] prod;
    } t_mm_res;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/g3ne_div.sv @@
// ----------------------------------------------------------------------------
// g3ne_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module g3ne_div import g3ne_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [LAB_W-1:0] i_dividend,
    input  logic [TOT_W-1:0] i_divisor,
    output t_div_res         o_res
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LAB_W-1:0] r_quo;
    logic [TOT_W-1:0] r_rem;
    logic [TOT_W-1:0] r_dvs;

    logic [TOT_W:0]   w_trial;
    logic [TOT_W:0]   w_diff;
    logic             w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[LAB_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LAB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[LAB_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TOT_W-1:0] : w_trial[TOT_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

@@ sv/g3ne_mulmod.sv @@
// ----------------------------------------------------------------------------
// g3ne_mulmod
// bit-serial modular multiplier, multiplier msb first, a doubling and an add step per bit
// ----------------------------------------------------------------------------
module g3ne_mulmod import g3ne_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LAB_W-1:0]  i_a,
    input  logic [MULT_W-1:0] i_mult,
    input  logic [TOT_W-1:0]  i_mod,
    output t_mm_res           o_res
);

    logic              r_busy;
    logic              r_done;
    logic              r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic [MULT_W-1:0] r_mul;
    logic [TOT_W-1:0]  r_acc;
    logic [LAB_W-1:0]  r_a;
    logic [TOT_W-1:0]  r_mod;

    logic [TOT_W:0]    w_addend;
    logic [TOT_W:0]    w_pre;
    logic [TOT_W:0]    w_sub;
    logic              w_ge;

    // phase 0 doubles the accumulator, phase 1 adds a when the bit is set
    assign w_addend = r_mul[MULT_W-1] ? (TOT_W+1)'(r_a) : '0;
    assign w_pre    = r_phase ? ({1'b0, r_acc} + w_addend) : {r_acc, 1'b0};
    assign w_sub    = w_pre - {1'b0, r_mod};
    assign w_ge     = (w_pre >= {1'b0, r_mod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MULT_W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mul <= i_mult;
            r_a   <= i_a;
            r_mod <= i_mod;
        end else if (r_busy) begin
            r_acc <= w_ge ? w_sub[TOT_W-1:0] : w_pre[TOT_W-1:0];
            if (r_phase) begin
                r_mul <= {r_mul[MULT_W-2:0], 1'b0};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_acc[LAB_W-1:0];

endmodule

@@ sv/grid3d_neighbor_edge_generator_top.sv @@
// ----------------------------------------------------------------------------
// grid3d_neighbor_edge_generator_top
// six-point stencil neighbor edge generator for a 3d grid graph
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) takes one vertex number per word.
//   output channel (o_out_valid / i_out_ready) gives one word per existing
//   face neighbor in the order z+1, z-1, y+1, y-1, x+1, x-1, the final one
//   flagged by o_last; an isolated vertex gives a single word with
//   o_has_edge low.
//   the apb port sets the grid extents, base, label mode and hash multiplier;
//   write it only while the block is idle.
// timing:
//   one vertex at a time; the words of a vertex follow one per cycle while the
//   receiver is ready. the wait for the first word is set by the bit-serial
//   divider (label mod total, then label / (x*y extent), then the rest / x
//   extent, 30 steps each) and, in hashed mode, the modular multiplier (a
//   doubling and an add step per multiplier bit, 31 bits).
// reset and stall:
//   synchronous reset restores the register defaults and clears the edge
//   count. a stalled receiver holds the output word; the next vertex is taken
//   as soon as the last word of the current one sits in the output register.
// ----------------------------------------------------------------------------
module grid3d_neighbor_edge_generator_top import g3ne_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // vertex input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [LAB_W-1:0]  i_vertex_number,
    // edge output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OUT_W-1:0]  o_vertex_label,
    output logic [EDGE_W-1:0] o_first_edge_index,
    output logic [OUT_W-1:0]  o_neighbor_label,
    output logic [WGT_W-1:0]  o_edge_weight,
    output logic              o_has_edge,
    output logic              o_last,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [DIM_W-1:0]  r_first_dim;
    logic [DIM_W-1:0]  r_second_dim;
    logic [DIM_W-1:0]  r_third_dim;
    logic              r_base_value;
    logic              r_label_mode;
    logic [MULT_W-1:0] r_hash_mult;

    t_state            r_state;
    t_state            n_state;

    logic [LAB_W-1:0]  r_num;
    logic [HW_W-1:0]   r_hw;
    logic [TOT_W-1:0]  r_total;
    logic [LAB_W-1:0]  r_lab;
    logic [HW_W-1:0]   r_rem;
    logic [DIM_W-1:0]  r_x;
    logic [DIM_W-1:0]  r_y;
    logic [DIM_W-1:0]  r_z;
    logic [EDGE_W-1:0] r_first;
    logic [EDGE_W-1:0] r_edge_count;
    logic [MAX_NEIGHBORS-1:0] r_sent;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_vertex_label;
    logic [EDGE_W-1:0] r_first_edge_index;
    logic [OUT_W-1:0]  r_neighbor_label;
    logic [WGT_W-1:0]  r_edge_weight;
    logic              r_has_edge;
    logic              r_last;

    t_reg_idx          w_idx;
    logic              w_wr;
    logic [DIM_W-1:0]  w_h;
    logic [DIM_W-1:0]  w_w;
    logic [DIM_W-1:0]  w_d;

    logic              w_accept;
    logic              w_div_start;
    logic              w_mm_start;
    logic              w_emit;
    logic [LAB_W-1:0]  w_div_dividend;
    logic [TOT_W-1:0]  w_div_divisor;
    t_div_res          w_div;
    t_mm_res           w_mm;

    logic [MAX_NEIGHBORS-1:0] w_mask;
    logic [MAX_NEIGHBORS-1:0] w_remain;
    logic [MAX_NEIGHBORS-1:0] w_pick;
    logic              w_isolated;
    logic              w_last;
    logic              w_out_free;
    logic [HW_W-1:0]   w_off;
    logic              w_neg;
    logic [OUT_W-1:0]  w_nb;
    logic [OUT_W-1:0]  w_vl;
    logic [OUT_W-1:0]  w_nl;
    logic [WGT_BITS-1:0] w_wsum;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_dim  <= DIM_W'(1);
            r_second_dim <= DIM_W'(1);
            r_third_dim  <= DIM_W'(1);
            r_base_value <= 1'b0;
            r_label_mode <= 1'b0;
            r_hash_mult  <= MULT_W'(1);
        end else if (w_wr) begin
            case (w_idx)
                REG_FIRST_DIM:  r_first_dim  <= pwdata[DIM_W-1:0];
                REG_SECOND_DIM: r_second_dim <= pwdata[DIM_W-1:0];
                REG_THIRD_DIM:  r_third_dim  <= pwdata[DIM_W-1:0];
                REG_BASE_VALUE: r_base_value <= pwdata[0];
                REG_LABEL_MODE: r_label_mode <= pwdata[0];
                REG_HASH_MULT:  r_hash_mult  <= pwdata[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FIRST_DIM:  prdata = DATA_W'(r_first_dim);
            REG_SECOND_DIM: prdata = DATA_W'(r_second_dim);
            REG_THIRD_DIM:  prdata = DATA_W'(r_third_dim);
            REG_BASE_VALUE: prdata = DATA_W'(r_base_value);
            REG_LABEL_MODE: prdata = DATA_W'(r_label_mode);
            REG_HASH_MULT:  prdata = DATA_W'(r_hash_mult);
            default:        prdata = '0;
        endcase
    end

    assign w_h = dim_clamp(r_first_dim);
    assign w_w = dim_clamp(r_second_dim);
    assign w_d = dim_clamp(r_third_dim);

    // ---------------- serial units ----------------
    always_comb begin
        case (r_state)
            ST_MOD_GO: begin
                w_div_dividend = r_num;
                w_div_divisor  = r_total;
            end
            ST_Z_GO: begin
                w_div_dividend = r_lab;
                w_div_divisor  = TOT_W'(r_hw);
            end
            default: begin
                w_div_dividend = LAB_W'(r_rem);
                w_div_divisor  = TOT_W'(w_h);
            end
        endcase
    end

    g3ne_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_res      (w_div)
    );

    g3ne_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mm_start),
        .i_a     (r_lab),
        .i_mult  (r_hash_mult),
        .i_mod   (r_total),
        .o_res   (w_mm)
    );

    // ---------------- neighbor selection ----------------
    always_comb begin
        w_mask = '0;
        w_mask[DIR_ZP] = (({1'b0, r_z} + (DIM_W+1)'(1)) < {1'b0, w_d});
        w_mask[DIR_ZM] = (r_z != '0);
        w_mask[DIR_YP] = (({1'b0, r_y} + (DIM_W+1)'(1)) < {1'b0, w_w});
        w_mask[DIR_YM] = (r_y != '0);
        w_mask[DIR_XP] = (({1'b0, r_x} + (DIM_W+1)'(1)) < {1'b0, w_h});
        w_mask[DIR_XM] = (r_x != '0);
    end

    assign w_remain   = w_mask & ~r_sent;
    // lowest pending direction
    assign w_pick     = w_remain & (~w_remain + MAX_NEIGHBORS'(1));
    assign w_isolated = (w_mask == '0);
    assign w_last     = w_isolated || ((w_remain & ~w_pick) == '0);

    assign w_off = (w_pick[DIR_ZP] || w_pick[DIR_ZM]) ? r_hw :
                   (w_pick[DIR_YP] || w_pick[DIR_YM]) ? HW_W'(w_h) : HW_W'(1);
    assign w_neg = w_pick[DIR_ZM] || w_pick[DIR_YM] || w_pick[DIR_XM];
    assign w_nb  = w_neg ? (OUT_W'(r_lab) - OUT_W'(w_off))
                         : (OUT_W'(r_lab) + OUT_W'(w_off));
    assign w_vl  = OUT_W'(r_lab) + OUT_W'(r_base_value);
    assign w_nl  = w_nb + OUT_W'(r_base_value);
    assign w_wsum = w_vl[WGT_BITS-1:0] + w_nl[WGT_BITS-1:0];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_mm_start  = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_TOTAL;
            end
            ST_TOTAL: begin
                n_state = ST_MOD_GO;
            end
            ST_MOD_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (w_div.done) n_state = r_label_mode ? ST_HASH_GO : ST_Z_GO;
            end
            ST_HASH_GO: begin
                w_mm_start = 1'b1;
                n_state    = ST_HASH_WAIT;
            end
            ST_HASH_WAIT: begin
                if (w_mm.done) n_state = ST_Z_GO;
            end
            ST_Z_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_Z_WAIT;
            end
            ST_Z_WAIT: begin
                if (w_div.done) n_state = ST_Y_GO;
            end
            ST_Y_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_Y_WAIT;
            end
            ST_Y_WAIT: begin
                if (w_div.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (w_last) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_sent       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == ST_Y_WAIT && w_div.done) begin
                r_sent <= '0;
            end else if (w_emit) begin
                r_sent <= r_sent | w_pick;
            end
            if (w_emit && !w_isolated) begin
                r_edge_count <= r_edge_count + EDGE_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num <= i_vertex_number;
            r_hw  <= HW_W'(w_h) * HW_W'(w_w);
        end
        if (r_state == ST_TOTAL) begin
            r_total <= TOT_W'(r_hw) * TOT_W'(w_d);
        end
        if (r_state == ST_MOD_WAIT && w_div.done) begin
            r_lab <= w_div.rem[LAB_W-1:0];
        end
        if (r_state == ST_HASH_WAIT && w_mm.done) begin
            r_lab <= w_mm.prod;
        end
        if (r_state == ST_Z_WAIT && w_div.done) begin
            r_z   <= w_div.quot[DIM_W-1:0];
            r_rem <= w_div.rem[HW_W-1:0];
        end
        if (r_state == ST_Y_WAIT && w_div.done) begin
            r_y     <= w_div.quot[DIM_W-1:0];
            r_x     <= w_div.rem[DIM_W-1:0];
            r_first <= r_edge_count + EDGE_W'(r_base_value);
        end
        if (w_emit) begin
            r_vertex_label     <= w_vl;
            r_first_edge_index <= r_first;
            r_has_edge         <= !w_isolated;
            r_last             <= w_last;
            if (w_isolated) begin
                r_neighbor_label <= '0;
                r_edge_weight    <= '0;
            end else begin
                r_neighbor_label <= w_nl;
                r_edge_weight    <= {1'b0, w_wsum} + WGT_W'(1);
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_vertex_label     = r_vertex_label;
    assign o_first_edge_index = r_first_edge_index;
    assign o_neighbor_label   = r_neighbor_label;
    assign o_edge_weight      = r_edge_weight;
    assign o_has_edge         = r_has_edge;
    assign o_last             = r_last;

endmodule

@@ sv/g3ne_checker.sv @@
// ----------------------------------------------------------------------------
// g3ne_checker
// port-level checks of the grid neighbor edge generator
// ----------------------------------------------------------------------------
module g3ne_checker import g3ne_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [OUT_W-1:0]  o_vertex_label,
    input logic [EDGE_W-1:0] o_first_edge_index,
    input logic [OUT_W-1:0]  o_neighbor_label,
    input logic [WGT_W-1:0]  o_edge_weight,
    input logic              o_has_edge,
    input logic              o_last
);

    logic [WGT_BITS-1:0] w_wsum;

    assign w_wsum = o_vertex_label[WGT_BITS-1:0] + o_neighbor_label[WGT_BITS-1:0];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word present after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_vertex_label) && $stable(o_neighbor_label)
            && $stable(o_first_edge_index) && $stable(o_last))
        else $error("stalled output word changed");

    a_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_edge |->
            o_last && o_edge_weight == '0 && o_neighbor_label == '0)
        else $error("word without edge is malformed");

    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_edge |->
            o_edge_weight == ({1'b0, w_wsum} + WGT_W'(1)))
        else $error("edge weight does not match labels");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("new vertex taken before the current one finished");

endmodule

bind grid3d_neighbor_edge_generator_top g3ne_checker u_g3ne_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives vertex numbers into the 3d grid neighbor edge generator and checks
// every output word against a behavioral six-point stencil predictor: a table
// of directed corner, clamp and hashing cases, then random grids and vertices
// with random stalls on both channels and a long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;
    import g3ne_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int DIM_FIELD_MAX = (1 << DIM_W) - 1;

    // register slots with nothing behind them
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [OUT_W-1:0]  vertex_label;
        logic [EDGE_W-1:0] first_edge;
        logic [OUT_W-1:0]  nbr_label;
        logic [WGT_W-1:0]  weight;
        logic              has_edge;
        logic              last;
    } t_edge_word;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic        typed;
        t_edge_word  want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [LAB_W-1:0]  i_vertex_number = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [OUT_W-1:0]  o_vertex_label;
    logic [EDGE_W-1:0] o_first_edge_index;
    logic [OUT_W-1:0]  o_neighbor_label;
    logic [WGT_W-1:0]  o_edge_weight;
    logic              o_has_edge;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor copy of the registers and the running edge count
    logic [DIM_W-1:0]  grid_dim [3];
    logic              grid_base;
    logic              hashed_mode;
    logic [MULT_W-1:0] hash_mult;
    logic [EDGE_W-1:0] edge_total;

    t_edge_word calc_words [MAX_NEIGHBORS];
    int         calc_cnt;
    t_edge_word pending_edges [$];
    t_stim_row  dir_rows [$];
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    int         hold_asked = 0;
    int         hold_served = 0;
    bit         no_idle = 1'b0;

    grid3d_neighbor_edge_generator_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_vertex_number    (i_vertex_number),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_vertex_label     (o_vertex_label),
        .o_first_edge_index (o_first_edge_index),
        .o_neighbor_label   (o_neighbor_label),
        .o_edge_weight      (o_edge_weight),
        .o_has_edge         (o_has_edge),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic longint unsigned clamp_extent(input logic [DIM_W-1:0] v);
        return (v == '0) ? 64'd1 : ((v > DIM_W'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(v));
    endfunction

    function automatic longint unsigned vertex_total();
        return clamp_extent(grid_dim[0]) * clamp_extent(grid_dim[1])
             * clamp_extent(grid_dim[2]);
    endfunction

    // fills calc_words with the words one vertex number produces
    task automatic compute_neighbors(input logic [LAB_W-1:0] num);
        longint unsigned   nx, ny, nz, plane, span, prod, lab, x, y, z;
        longint unsigned   nbr [MAX_NEIGHBORS];
        logic [OUT_W-1:0]  vl, nl;
        logic [EDGE_W-1:0] first;
        t_edge_word        w;
        int                k, found;
        nx = clamp_extent(grid_dim[0]);
        ny = clamp_extent(grid_dim[1]);
        nz = clamp_extent(grid_dim[2]);
        plane = nx * ny;
        span = plane * nz;
        prod = num;
        if (hashed_mode) begin
            prod = prod * hash_mult;
        end
        lab = prod % span;
        z = lab / plane;
        y = (lab % plane) / nx;
        x = lab % nx;
        found = 0;
        if (z + 1 < nz) begin
            nbr[found] = lab + plane;
            found += 1;
        end
        if (z > 0) begin
            nbr[found] = lab - plane;
            found += 1;
        end
        if (y + 1 < ny) begin
            nbr[found] = lab + nx;
            found += 1;
        end
        if (y > 0) begin
            nbr[found] = lab - nx;
            found += 1;
        end
        if (x + 1 < nx) begin
            nbr[found] = lab + 1;
            found += 1;
        end
        if (x > 0) begin
            nbr[found] = lab - 1;
            found += 1;
        end
        vl = OUT_W'(lab + grid_base);
        first = edge_total + EDGE_W'(grid_base);
        if (found == 0) begin
            // lone vertex: one word, no edge, count unchanged
            w = '0;
            w.vertex_label = vl;
            w.first_edge = first;
            w.last = 1'b1;
            calc_words[0] = w;
            calc_cnt = 1;
        end else begin
            for (k = 0; k < found; k++) begin
                nl = OUT_W'(nbr[k] + grid_base);
                w.vertex_label = vl;
                w.first_edge = first;
                w.nbr_label = nl;
                w.weight = WGT_W'((vl + nl) % WEIGHT_MOD + 1);
                w.has_edge = 1'b1;
                w.last = (k == found - 1);
                calc_words[k] = w;
            end
            calc_cnt = found;
            edge_total = edge_total + EDGE_W'(found);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FIRST_DIM:  grid_dim[0] = val[DIM_W-1:0];
            REG_SECOND_DIM: grid_dim[1] = val[DIM_W-1:0];
            REG_THIRD_DIM:  grid_dim[2] = val[DIM_W-1:0];
            REG_BASE_VALUE: grid_base = val[0];
            REG_LABEL_MODE: hashed_mode = val[0];
            REG_HASH_MULT:  hash_mult = val[MULT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic push_vertex(input logic [LAB_W-1:0] num, input logic typed,
                               input t_edge_word want);
        int gap;
        int k;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_vertex_number <= num;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        compute_neighbors(num);
        if (typed) begin
            pending_edges.push_back(want);
        end else begin
            for (k = 0; k < calc_cnt; k++) begin
                pending_edges.push_back(calc_words[k]);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_edges.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_stim_row cfg_row(input logic [2:0] idx, input logic [31:0] val);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [LAB_W-1:0] num);
        t_stim_row r;
        r = '0;
        r.value = 32'(num);
        return r;
    endfunction

    // lone vertex with its single word written out
    function automatic t_stim_row lone_row(input logic [LAB_W-1:0] num,
                                           input logic [OUT_W-1:0] vl,
                                           input logic [EDGE_W-1:0] first);
        t_stim_row r;
        r = item_row(num);
        r.typed = 1'b1;
        r.want.vertex_label = vl;
        r.want.first_edge = first;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] pick_extent();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 1;
            2: v = MAX_DIM;
            3: v = $urandom_range(MAX_DIM + 1, DIM_FIELD_MAX);
            4: v = $urandom_range(1, MAX_DIM);
            default: v = $urandom_range(2, 9);
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v = v | ($urandom & ~32'(DIM_FIELD_MAX));
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_mult();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 1;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [LAB_W-1:0] pick_vertex();
        longint unsigned span;
        logic [LAB_W-1:0] v;
        span = vertex_total();
        case ($urandom_range(0, 4))
            0: v = LAB_W'($urandom);
            1: v = LAB_W'(span - 1);
            default: v = LAB_W'($urandom_range(0, 32'(span - 1)));
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_cnt += 1;
        end
    endtask

    always @(posedge i_clk) begin : word_check
        t_edge_word got;
        t_edge_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.vertex_label = o_vertex_label;
            got.first_edge = o_first_edge_index;
            got.nbr_label = o_neighbor_label;
            got.weight = o_edge_weight;
            got.has_edge = o_has_edge;
            got.last = o_last;
            if (pending_edges.size() == 0) begin
                $display("%0t: word expected none, got vertex 0x%0h neighbor 0x%0h",
                         $time, got.vertex_label, got.nbr_label);
                mismatch_cnt += 1;
            end else begin
                want = pending_edges.pop_front();
                check_field("vertex_label", want.vertex_label, got.vertex_label);
                check_field("first_edge_index", want.first_edge, got.first_edge);
                check_field("neighbor_label", want.nbr_label, got.nbr_label);
                check_field("edge_weight", want.weight, got.weight);
                check_field("has_edge", want.has_edge, got.has_edge);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: random stall per word, plus one long hold-off on request
    initial begin : out_side
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_served != hold_asked) begin
                hold_served += 1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_edge_word  none;
        t_stim_row   row;
        logic [31:0] word;
        int          p, k;
        grid_dim[0] = 1;
        grid_dim[1] = 1;
        grid_dim[2] = 1;
        grid_base = 1'b0;
        hashed_mode = 1'b0;
        hash_mult = 1;
        edge_total = '0;
        none = '0;

        dir_rows.push_back(lone_row(0, 0, 0));
        dir_rows.push_back(lone_row('1, 0, 0));
        dir_rows.push_back(cfg_row(REG_BASE_VALUE, 32'hFFFF_FFFF));
        dir_rows.push_back(lone_row(30'd12345, 1, 1));
        dir_rows.push_back(cfg_row(REG_SPARE_A, 32'd5));
        dir_rows.push_back(cfg_row(REG_SPARE_B, 32'd3));
        dir_rows.push_back(lone_row(1, 1, 1));
        dir_rows.push_back(cfg_row(REG_BASE_VALUE, 32'd0));
        // zero extent reads as one, oversized extent as the maximum
        dir_rows.push_back(cfg_row(REG_FIRST_DIM, 32'd0));
        dir_rows.push_back(cfg_row(REG_SECOND_DIM, 32'(DIM_FIELD_MAX)));
        dir_rows.push_back(item_row(0));
        dir_rows.push_back(item_row(MAX_DIM - 1));
        dir_rows.push_back(item_row(MAX_DIM));
        dir_rows.push_back(item_row('1));
        dir_rows.push_back(cfg_row(REG_FIRST_DIM, MAX_DIM));
        dir_rows.push_back(cfg_row(REG_SECOND_DIM, MAX_DIM));
        dir_rows.push_back(cfg_row(REG_THIRD_DIM, MAX_DIM));
        dir_rows.push_back(item_row(0));
        dir_rows.push_back(item_row('1));
        dir_rows.push_back(item_row(1 + MAX_DIM + MAX_DIM * MAX_DIM));
        dir_rows.push_back(cfg_row(REG_BASE_VALUE, 32'd1));
        dir_rows.push_back(item_row('1));
        dir_rows.push_back(item_row(5 * MAX_DIM * MAX_DIM + 3 * MAX_DIM + 7));
        dir_rows.push_back(cfg_row(REG_FIRST_DIM, 32'd3));
        dir_rows.push_back(cfg_row(REG_SECOND_DIM, 32'd4));
        dir_rows.push_back(cfg_row(REG_THIRD_DIM, 32'd5));
        dir_rows.push_back(cfg_row(REG_LABEL_MODE, 32'd1));
        dir_rows.push_back(cfg_row(REG_HASH_MULT, 32'd7));
        dir_rows.push_back(item_row(0));
        dir_rows.push_back(item_row(1));
        dir_rows.push_back(item_row('1));
        dir_rows.push_back(item_row(59));
        dir_rows.push_back(cfg_row(REG_HASH_MULT, 32'h7FFF_FFFF));
        dir_rows.push_back(item_row('1));
        dir_rows.push_back(item_row(30'd123456789));
        // zero multiplier folds every number onto label zero
        dir_rows.push_back(cfg_row(REG_HASH_MULT, 32'd0));
        dir_rows.push_back(item_row(30'h2AAA_AAAA));
        dir_rows.push_back(item_row(30'h1555_5555));
        dir_rows.push_back(cfg_row(REG_LABEL_MODE, 32'd0));
        dir_rows.push_back(cfg_row(REG_BASE_VALUE, 32'd0));
        dir_rows.push_back(cfg_row(REG_FIRST_DIM, 32'd2));
        dir_rows.push_back(cfg_row(REG_SECOND_DIM, 32'd1));
        dir_rows.push_back(cfg_row(REG_THIRD_DIM, 32'd1));
        dir_rows.push_back(item_row(0));
        dir_rows.push_back(item_row(1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < dir_rows.size(); k++) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                wait_drained();
                write_reg(row.reg_idx, row.value);
            end else begin
                push_vertex(row.value[LAB_W-1:0], row.typed, row.want);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            no_idle = (p == 1);
            write_reg(REG_FIRST_DIM, pick_extent());
            write_reg(REG_SECOND_DIM, pick_extent());
            write_reg(REG_THIRD_DIM, pick_extent());
            write_reg(REG_BASE_VALUE, $urandom);
            word = $urandom;
            word[0] = p[0];
            write_reg(REG_LABEL_MODE, word);
            write_reg(REG_HASH_MULT, pick_mult());
            write_reg(p[0] ? REG_SPARE_A : REG_SPARE_B, $urandom);
            // receiver stops long enough for the block to back up its input
            if (p == 3) begin
                hold_asked += 1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 4 && k == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                push_vertex(pick_vertex(), 1'b0, none);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/g3ne_pkg.sv
sv/g3ne_div.sv
sv/g3ne_mulmod.sv
sv/grid3d_neighbor_edge_generator_top.sv
sv/g3ne_checker.sv
tb/testbench.sv
